FILE: rtl/rwce_pkg.sv
// ----------------------------------------------------------------------------
// rwce_pkg
// Shared types, codes and sizes for the windowed RMS column engine.
// ----------------------------------------------------------------------------
package rwce_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SPAN_MAX   = 4096;
  localparam int SPAN_W     = 13;
  localparam int ACC_W      = 43;
  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_STEPS = 16;
  localparam int ITER_W     = 6;
  localparam int ADDR_W     = 4;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_RENDER = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NUM_CH = 2'd0,
    REG_SPAN   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_SQRT,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic push;
    logic clear;
    logic rend_start;
    logic setup;
    logic rd_step;
    logic div_start;
    logic div_step;
    logic sqrt_step;
    logic scale;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic col_ok;
    logic rd_last;
    logic pipe_busy;
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/rwce_ctrl.sv
// ----------------------------------------------------------------------------
// rwce_ctrl
// Sequencer: clearing pass, accept, read walk, divide, root, scale, output.
// ----------------------------------------------------------------------------
module rwce_ctrl
  import rwce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_stall,
  input  sts_t       sts,
  output ctl_t       ctl
);

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_fire = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_CLEAR) state_nxt = ST_CLEAR;
        else if (in_fire && in_cmd == CMD_RENDER && sts.col_ok) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_READ;
      ST_READ:  if (sts.rd_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!sts.pipe_busy) state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_SQRT;
      ST_SQRT:  if (sts.sqrt_last) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall       = 1'b0;
        ctl.push       = in_fire && in_cmd == CMD_PUSH;
        ctl.clear      = in_fire && in_cmd == CMD_CLEAR;
        ctl.rend_start = in_fire && in_cmd == CMD_RENDER && sts.col_ok;
      end
      ST_SETUP: ctl.setup     = 1'b1;
      ST_READ:  ctl.rd_step   = 1'b1;
      ST_DRAIN: ctl.div_start = !sts.pipe_busy;
      ST_DIV:   ctl.div_step  = 1'b1;
      ST_SQRT:  ctl.sqrt_step = 1'b1;
      ST_SCALE: ctl.scale     = 1'b1;
      ST_OUT:   ctl.out_load  = sts.out_free;
      default:  ctl = '0;
    endcase
  end

endmodule

FILE: rtl/rwce_dp.sv
// ----------------------------------------------------------------------------
// rwce_dp
// History store, write pointer, square-accumulate, divider, root, gain.
// ----------------------------------------------------------------------------
module rwce_dp
  import rwce_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  output sts_t                     sts,
  input  logic [1:0]               num_channels,
  input  logic [SPAN_W-1:0]        samples_per_column,
  input  logic [10:0]              display_width,
  input  logic [9:0]               bar_gain,
  input  logic signed [15:0]       in_sample_ch0,
  input  logic signed [15:0]       in_sample_ch1,
  input  logic [9:0]               in_column,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [9:0]               out_column,
  output logic [9:0]               out_bar_height,
  output logic                     out_frame_last
);

  logic signed [15:0] hist_mem [HIST_DEPTH];

  logic [HIST_AW-1:0] clr_cnt_r;
  logic [HIST_AW-1:0] wpos_r;
  logic [HIST_AW-1:0] fhead_r;
  logic [HIST_AW-1:0] head_r;
  logic [HIST_AW-1:0] rd_idx_r;
  logic [SPAN_W-1:0]  rd_cnt_r;
  logic [SPAN_W-1:0]  n_r;
  logic [10:0]        back_r;
  logic [9:0]         col_r;
  logic               last_r;
  logic signed [15:0] rd_data_r;
  logic [30:0]        sq_r;
  logic               v1_r, v2_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   quo_r;
  logic [SPAN_W-2:0]  rem_r;
  logic [17:0]        srem_r;
  logic [15:0]        root_r;
  logic [ITER_W-1:0]  iter_r;
  logic [25:0]        prod_r;
  logic               out_valid_r;
  logic [9:0]         out_col_r, out_bar_r;
  logic               out_last_r;

  logic signed [16:0] pair_sum;
  logic signed [15:0] mono;
  logic [SPAN_W-1:0]  n_eff;
  logic [23:0]        base_prod;
  logic [SPAN_W-1:0]  dtrial;
  logic               dge;
  logic [19:0]        strial, sshift;
  logic               sge;
  logic [31:0]        sq_full;
  logic [10:0]        bar_raw;

  assign pair_sum = 17'(in_sample_ch0) + 17'(in_sample_ch1);
  assign mono     = (num_channels == 2'd2) ? pair_sum[16:1] : in_sample_ch0;

  always_comb begin
    if (samples_per_column == '0)               n_eff = SPAN_W'(1);
    else if (samples_per_column > SPAN_W'(SPAN_MAX)) n_eff = SPAN_W'(SPAN_MAX);
    else                                        n_eff = samples_per_column;
  end

  assign base_prod = back_r * n_r;
  assign dtrial    = {rem_r, quo_r[ACC_W-1]};
  assign dge       = dtrial >= n_r;
  assign sshift    = {srem_r, quo_r[31:30]};
  assign strial    = {2'b00, root_r, 2'b01};
  assign sge       = sshift >= strial;
  assign sq_full   = rd_data_r * rd_data_r;
  assign bar_raw   = prod_r[25:15];

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      hist_mem[clr_cnt_r] <= '0;
    end else if (ctl.push) begin
      hist_mem[wpos_r] <= mono;
    end
    rd_data_r <= hist_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      wpos_r      <= '0;
      fhead_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ctl.clear) wpos_r <= '0;
      else if (ctl.push) wpos_r <= wpos_r + 1'b1;
      if (ctl.rend_start && in_column == '0) fhead_r <= wpos_r;
      v1_r <= ctl.rd_step;
      v2_r <= v1_r;
      if (ctl.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rend_start) begin
      col_r  <= in_column;
      last_r <= {1'b0, in_column} == display_width - 11'd1;
      back_r <= display_width - {1'b0, in_column} - 11'd1;
      n_r    <= n_eff;
      head_r <= (in_column == '0) ? wpos_r : fhead_r;
    end
    if (ctl.setup) begin
      rd_idx_r <= head_r - base_prod[HIST_AW-1:0];
      rd_cnt_r <= n_r;
      acc_r    <= '0;
    end else if (ctl.rd_step) begin
      rd_idx_r <= rd_idx_r - 1'b1;
      rd_cnt_r <= rd_cnt_r - 1'b1;
    end
    sq_r <= sq_full[30:0];
    if (v2_r) acc_r <= acc_r + ACC_W'(sq_r);

    if (ctl.div_start) begin
      quo_r  <= acc_r;
      rem_r  <= '0;
      srem_r <= '0;
      root_r <= '0;
      iter_r <= '0;
    end else if (ctl.div_step) begin
      rem_r  <= dge ? (SPAN_W-1)'(dtrial - n_r) : dtrial[SPAN_W-2:0];
      quo_r  <= {quo_r[ACC_W-2:0], dge};
      iter_r <= sts.div_last ? '0 : iter_r + 1'b1;
    end else if (ctl.sqrt_step) begin
      srem_r <= sge ? 18'(sshift - strial) : sshift[17:0];
      root_r <= {root_r[14:0], sge};
      quo_r  <= {quo_r[ACC_W-3:0], 2'b00};
      iter_r <= iter_r + 1'b1;
    end
    if (ctl.scale) prod_r <= root_r * bar_gain;
    if (ctl.out_load) begin
      out_col_r  <= col_r;
      out_bar_r  <= (bar_raw > 11'd1023) ? 10'd1023 : bar_raw[9:0];
      out_last_r <= last_r;
    end
  end

  always_comb begin
    sts.clr_last  = clr_cnt_r == '1;
    sts.col_ok    = {1'b0, in_column} < display_width;
    sts.rd_last   = rd_cnt_r == SPAN_W'(1);
    sts.pipe_busy = v1_r || v2_r;
    sts.div_last  = iter_r == ITER_W'(DIV_STEPS - 1);
    sts.sqrt_last = iter_r == ITER_W'(SQRT_STEPS - 1);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_column     = out_col_r;
  assign out_bar_height = out_bar_r;
  assign out_frame_last = out_last_r;

endmodule

FILE: rtl/rms_waveform_column_engine_unit.sv
// ----------------------------------------------------------------------------
// rms_waveform_column_engine_unit
// Windowed RMS envelope engine: mono history store and per-column bar height.
// ----------------------------------------------------------------------------
// Input channel (in_*): valid/stall. cmd 0 pushes one mono sample (average of
// two channels when num_channels is 2) into a 4096-entry history; cmd 1
// renders a display column; cmd 2 clears the history; cmd 3 is dropped.
// Push, ignored and out-of-range renders are taken without leaving idle; a
// clear command starts a clearing pass. A render makes one memory read per
// history sample (samples_per_column of them), then runs a 43-step divider and a 16-step root unit.
// Result channel (out_*): one beat per in-range render, held in an output
// register; a stalled result holds and the next item is still taken, but a
// render cannot finish until the held result has gone.
// Reset, and every clear command, run a clearing pass over all 4096 entries of
// the history memory with in_stall high; APB writes are taken at all times and
// are meant only while no render is in flight.
// ----------------------------------------------------------------------------
module rms_waveform_column_engine_unit
  import rwce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic signed [15:0] in_sample_ch0,
  input  logic signed [15:0] in_sample_ch1,
  input  logic [9:0]        in_column,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [9:0]        out_column,
  output logic [9:0]        out_bar_height,
  output logic              out_frame_last
);

  logic [1:0]        num_ch_r;
  logic [SPAN_W-1:0] span_r;
  logic [10:0]       width_r;
  logic [9:0]        gain_r;
  logic              wr_en;
  reg_idx_t          ridx;
  ctl_t              ctl;
  sts_t              sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r <= 2'd2;
      span_r   <= SPAN_W'(4);
      width_r  <= 11'd256;
      gain_r   <= 10'd115;
    end else if (wr_en) begin
      unique case (ridx)
        REG_NUM_CH: num_ch_r <= pwdata[1:0];
        REG_SPAN:   span_r   <= pwdata[SPAN_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[10:0];
        REG_GAIN:   gain_r   <= pwdata[9:0];
        default:    num_ch_r <= num_ch_r;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_NUM_CH: prdata = 32'(num_ch_r);
      REG_SPAN:   prdata = 32'(span_r);
      REG_WIDTH:  prdata = 32'(width_r);
      REG_GAIN:   prdata = 32'(gain_r);
      default:    prdata = '0;
    endcase
  end

  rwce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  rwce_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .num_channels       (num_ch_r),
    .samples_per_column (span_r),
    .display_width      (width_r),
    .bar_gain           (gain_r),
    .in_sample_ch0      (in_sample_ch0),
    .in_sample_ch1      (in_sample_ch1),
    .in_column          (in_column),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_column         (out_column),
    .out_bar_height     (out_bar_height),
    .out_frame_last     (out_frame_last)
  );

endmodule

FILE: rtl/rwce_chk.sv
// ----------------------------------------------------------------------------
// rwce_chk
// Port-level checks for the RMS column engine, bound to the top level.
// ----------------------------------------------------------------------------
module rwce_chk
  import rwce_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [9:0]        out_bar_height,
  input logic [9:0]        out_column
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_bar_height) && $stable(out_column))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without a render in flight");

endmodule

bind rms_waveform_column_engine_unit rwce_chk u_rwce_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_bar_height (out_bar_height),
  .out_column     (out_column)
);
